// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the range slot allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wcrsa_pkg.sv =====
// ----------------------------------------------------------------------------
// wcrsa_pkg
// Widths, codes and status types shared by the range slot allocator modules.
// ----------------------------------------------------------------------------
package wcrsa_pkg;

  localparam int ADDR_W      = 52;  // address and length fields
  localparam int SIZE_W      = 54;  // rounded end, region size
  localparam int WORD_W      = 64;  // base and mask words
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 4;
  localparam int MAP_SLOTS   = 16;  // bits in the used map
  localparam int MAX_SLOTS   = 16;
  localparam int EFF_SLOTS   = (MAX_SLOTS < MAP_SLOTS) ? MAX_SLOTS : MAP_SLOTS;
  localparam int SLOT_CNT_W  = 5;
  localparam int PBITS_W     = 6;
  localparam int PAGE_BITS   = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [PBITS_W-1:0] PBITS_MIN     = 6'd32;
  localparam logic [PBITS_W-1:0] PBITS_MAX     = 6'd52;
  localparam logic [PBITS_W-1:0] PBITS_DEFAULT = 6'd36;

  localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RESET = 5'd8;

  localparam logic [WORD_W-1:0] TYPE_WC   = 64'h1;
  localparam logic [WORD_W-1:0] VALID_BIT = 64'h800;
  localparam logic [WORD_W-1:0] PAGE_LOW  = 64'hfff;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WC_AVAILABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_ADDR_BITS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREOWNED_SLOTS = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_WC    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SLOTS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 3'd4;

  // Outcome of a slot scan, valid for one cycle.
  typedef struct packed {
    logic hit;
    logic miss;
  } scan_stat_t;

endpackage

// ===== sv/wcrsa_size_unit.sv =====
// ----------------------------------------------------------------------------
// wcrsa_size_unit
// Doubles a power-of-two region size, one step a cycle, until the aligned
// region covers the page-rounded range.
// ----------------------------------------------------------------------------
module wcrsa_size_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [wcrsa_pkg::ADDR_W-1:0] addr,
  input  logic [wcrsa_pkg::ADDR_W-1:0] len,
  output logic                         found,
  output logic [wcrsa_pkg::SIZE_W-1:0] size,
  output logic [wcrsa_pkg::SIZE_W-1:0] low_mask,
  output logic [wcrsa_pkg::ADDR_W-1:0] base
);

  logic                         running;
  logic [wcrsa_pkg::ADDR_W-1:0] start_pg;
  logic [wcrsa_pkg::SIZE_W-1:0] end_pg;
  logic [wcrsa_pkg::SIZE_W-1:0] end_sum;
  logic [wcrsa_pkg::SIZE_W-1:0] base_full;
  logic [wcrsa_pkg::SIZE_W-1:0] cover_end;

  assign end_sum = {2'b00, addr} + {2'b00, len}
                 + wcrsa_pkg::SIZE_W'(wcrsa_pkg::PAGE_LOW);

  // low_mask always equals size - 1, so the aligned base needs no subtract.
  assign base_full = {2'b00, start_pg} & ~low_mask;
  assign cover_end = base_full + size;
  assign base      = base_full[wcrsa_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      found   <= 1'b0;
    end else begin
      found <= 1'b0;
      if (load) begin
        start_pg <= {addr[wcrsa_pkg::ADDR_W-1:wcrsa_pkg::PAGE_BITS],
                     {wcrsa_pkg::PAGE_BITS{1'b0}}};
        end_pg   <= {end_sum[wcrsa_pkg::SIZE_W-1:wcrsa_pkg::PAGE_BITS],
                     {wcrsa_pkg::PAGE_BITS{1'b0}}};
        size     <= wcrsa_pkg::SIZE_W'(1) << wcrsa_pkg::PAGE_BITS;
        low_mask <= wcrsa_pkg::SIZE_W'(wcrsa_pkg::PAGE_LOW);
        running  <= 1'b1;
      end else if (running) begin
        if (cover_end >= end_pg) begin
          running <= 1'b0;
          found   <= 1'b1;
        end else begin
          size     <= {size[wcrsa_pkg::SIZE_W-2:0], 1'b0};
          low_mask <= {low_mask[wcrsa_pkg::SIZE_W-2:0], 1'b1};
        end
      end
    end
  end

endmodule

// ===== sv/wcrsa_slot_scan.sv =====
// ----------------------------------------------------------------------------
// wcrsa_slot_scan
// Walks the slot map one slot a cycle and reports the lowest free slot.
// ----------------------------------------------------------------------------
module wcrsa_slot_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  logic [wcrsa_pkg::MAP_SLOTS-1:0]  used_in,
  input  logic [wcrsa_pkg::SLOT_CNT_W-1:0] count_in,
  output wcrsa_pkg::scan_stat_t            stat,
  output logic [wcrsa_pkg::SLOT_W-1:0]     slot
);

  logic                             running;
  logic [wcrsa_pkg::SLOT_CNT_W-1:0] idx;
  logic [wcrsa_pkg::SLOT_CNT_W-1:0] count;
  logic [wcrsa_pkg::MAP_SLOTS-1:0]  used;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      stat    <= '0;
    end else begin
      stat <= '0;
      if (load) begin
        idx     <= '0;
        count   <= count_in;
        used    <= used_in;
        running <= 1'b1;
      end else if (running) begin
        if (idx >= count) begin
          running   <= 1'b0;
          stat.miss <= 1'b1;
        end else if (!used[idx[wcrsa_pkg::SLOT_W-1:0]]) begin
          running  <= 1'b0;
          stat.hit <= 1'b1;
          slot     <= idx[wcrsa_pkg::SLOT_W-1:0];
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/wc_range_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// wc_range_slot_allocator_unit
// Covers a physical range with one naturally aligned power-of-two region,
// claims the lowest free variable range slot and builds its base and mask.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Words
// request   in         start & !busy        range_start_addr, range_length
// result    out        done (one cycle)     status, slot_index, base_word,
//                                           mask_word, region_size
// config    in         cfg_we               cfg_index, cfg_data
//
// A request with zero length, no write-combining support or no slots is
// answered in the cycle after acceptance, and busy never rises for it.
// Any other request runs the size steps (one compare per candidate size from
// 4 KiB up), then the slot steps (one per slot inspected, plus one when none
// is free), before done rises.
// Reset is synchronous; the receiver cannot stall, done is high one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wc_range_slot_allocator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [wcrsa_pkg::ADDR_W-1:0]       range_start_addr,
  input  logic [wcrsa_pkg::ADDR_W-1:0]       range_length,
  input  logic                               cfg_we,
  input  logic [wcrsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wcrsa_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                               done,
  output logic [wcrsa_pkg::STATUS_W-1:0]     status,
  output logic [wcrsa_pkg::SLOT_W-1:0]       slot_index,
  output logic [wcrsa_pkg::WORD_W-1:0]       base_word,
  output logic [wcrsa_pkg::WORD_W-1:0]       mask_word,
  output logic [wcrsa_pkg::SIZE_W-1:0]       region_size
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SIZE,
    S_SCAN
  } state_t;

  state_t state;

  // Configuration registers.
  logic                               wc_available;
  logic [wcrsa_pkg::SLOT_CNT_W-1:0]   slot_count;
  logic [wcrsa_pkg::PBITS_W-1:0]      phys_addr_bits;
  logic [wcrsa_pkg::MAP_SLOTS-1:0]    preowned_slots;

  // Slots claimed by earlier requests.
  logic [wcrsa_pkg::MAP_SLOTS-1:0]    slot_used_map;

  logic                               accept;
  logic                               early_err;
  logic [wcrsa_pkg::STATUS_W-1:0]     early_code;
  logic                               sz_load;
  logic                               sz_found;
  logic [wcrsa_pkg::SIZE_W-1:0]       sz_size;
  logic [wcrsa_pkg::SIZE_W-1:0]       sz_low_mask;
  logic [wcrsa_pkg::ADDR_W-1:0]       sz_base;
  logic                               scan_load;
  wcrsa_pkg::scan_stat_t              scan_stat;
  logic [wcrsa_pkg::SLOT_W-1:0]       scan_slot;
  logic [wcrsa_pkg::SLOT_CNT_W-1:0]   eff_count;
  logic [wcrsa_pkg::PBITS_W-1:0]      pbits;
  logic [wcrsa_pkg::WORD_W-1:0]       width_mask;
  logic [wcrsa_pkg::WORD_W-1:0]       mask_value;
  logic [wcrsa_pkg::WORD_W-1:0]       base_value;

  assign accept = start && !busy;

  // Early rejects, in priority order: zero length, then no write combining,
  // then no slots at all.
  always_comb begin
    early_err  = 1'b1;
    early_code = wcrsa_pkg::ST_ZERO_LEN;
    if (range_length == '0) begin
      early_code = wcrsa_pkg::ST_ZERO_LEN;
    end else if (!wc_available) begin
      early_code = wcrsa_pkg::ST_NO_WC;
    end else if (slot_count == '0) begin
      early_code = wcrsa_pkg::ST_NO_SLOTS;
    end else begin
      early_err  = 1'b0;
      early_code = wcrsa_pkg::ST_OK;
    end
  end

  assign sz_load   = accept && !early_err;
  assign scan_load = (state == S_SIZE) && sz_found;

  // Slot counts beyond the map are clipped to the slots that exist.
  assign eff_count =
    (slot_count > wcrsa_pkg::SLOT_CNT_W'(wcrsa_pkg::EFF_SLOTS))
      ? wcrsa_pkg::SLOT_CNT_W'(wcrsa_pkg::EFF_SLOTS) : slot_count;

  // An address width outside the architectural range falls back to 36 bits.
  assign pbits = (phys_addr_bits < wcrsa_pkg::PBITS_MIN ||
                  phys_addr_bits > wcrsa_pkg::PBITS_MAX)
                   ? wcrsa_pkg::PBITS_DEFAULT : phys_addr_bits;

  assign width_mask = ~({wcrsa_pkg::WORD_W{1'b1}} << pbits);
  assign mask_value = (width_mask
                       & ~wcrsa_pkg::WORD_W'(sz_low_mask)
                       & ~wcrsa_pkg::PAGE_LOW)
                      | wcrsa_pkg::VALID_BIT;
  assign base_value = (wcrsa_pkg::WORD_W'(sz_base) & ~wcrsa_pkg::PAGE_LOW)
                      | wcrsa_pkg::TYPE_WC;

  wcrsa_size_unit u_size (
    .clk      (clk),
    .rst      (rst),
    .load     (sz_load),
    .addr     (range_start_addr),
    .len      (range_length),
    .found    (sz_found),
    .size     (sz_size),
    .low_mask (sz_low_mask),
    .base     (sz_base)
  );

  wcrsa_slot_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .load     (scan_load),
    .used_in  (slot_used_map | preowned_slots),
    .count_in (eff_count),
    .stat     (scan_stat),
    .slot     (scan_slot)
  );

  // Configuration writes must arrive only while the block is idle; unchecked.
  always_ff @(posedge clk) begin
    if (rst) begin
      wc_available   <= 1'b1;
      slot_count     <= wcrsa_pkg::SLOT_COUNT_RESET;
      phys_addr_bits <= wcrsa_pkg::PBITS_DEFAULT;
      preowned_slots <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wcrsa_pkg::CFG_WC_AVAILABLE:   wc_available   <= cfg_data[0];
        wcrsa_pkg::CFG_SLOT_COUNT:     slot_count     <= cfg_data[wcrsa_pkg::SLOT_CNT_W-1:0];
        wcrsa_pkg::CFG_PHYS_ADDR_BITS: phys_addr_bits <= cfg_data[wcrsa_pkg::PBITS_W-1:0];
        wcrsa_pkg::CFG_PREOWNED_SLOTS: preowned_slots <= cfg_data;
      endcase
    end
  end

  // Sequencer: early reject, or size search, then slot scan, then result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      busy          <= 1'b0;
      done          <= 1'b0;
      slot_used_map <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (early_err) begin
              done        <= 1'b1;
              status      <= early_code;
              slot_index  <= '0;
              base_word   <= '0;
              mask_word   <= '0;
              region_size <= '0;
            end else begin
              state <= S_SIZE;
              busy  <= 1'b1;
            end
          end
        end
        S_SIZE: begin
          if (sz_found) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_stat.hit) begin
            state         <= S_IDLE;
            busy          <= 1'b0;
            done          <= 1'b1;
            status        <= wcrsa_pkg::ST_OK;
            slot_index    <= scan_slot;
            base_word     <= base_value;
            mask_word     <= mask_value;
            region_size   <= sz_size;
            slot_used_map <= slot_used_map
                             | (wcrsa_pkg::MAP_SLOTS'(1) << scan_slot);
          end else if (scan_stat.miss) begin
            state       <= S_IDLE;
            busy        <= 1'b0;
            done        <= 1'b1;
            status      <= wcrsa_pkg::ST_NO_FREE;
            slot_index  <= '0;
            base_word   <= '0;
            mask_word   <= '0;
            region_size <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // A result word is never shown while a request is still in progress.
  `ASSERT_IMPLIES(a_done_not_busy, clk, rst, done, !busy, "done while busy")

  // Every failed request returns all-zero payload.
  `ASSERT_IMPLIES(a_err_zero, clk, rst, done && status != wcrsa_pkg::ST_OK,
    slot_index == '0 && base_word == '0 && mask_word == '0 && region_size == '0,
    "error result carries nonzero payload")

  // A successful result claims its slot and reports a power-of-two region.
  `ASSERT_IMPLIES(a_ok_claim, clk, rst, done && status == wcrsa_pkg::ST_OK,
    slot_used_map[slot_index] && $onehot(region_size),
    "successful result without claimed slot or power-of-two size")

  // A zero-length request is rejected on the next cycle.
  `ASSERT_NEXT(a_zero_len, clk, rst, start && !busy && range_length == '0,
    done && status == wcrsa_pkg::ST_ZERO_LEN, "zero length not rejected")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the write-combining range slot allocator. A short
// table of hand-picked requests and register writes is walked first, then
// randomized phases follow, each with its own register setting. Every answer
// from the block is checked field by field against a typed answer or a model
// of the page rounding, the power-of-two region search and the slot claim.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 62;
  // Every request answers with exactly one word, so the block is idle once the
  // last expected word has arrived; a few spare cycles are still allowed.
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 80;
  localparam int CYCLE_LIMIT     = 400000;

  localparam logic [wcrsa_pkg::ADDR_W-1:0] ADDR_MAX = {wcrsa_pkg::ADDR_W{1'b1}};

  // One answer word from the block.
  typedef struct packed {
    logic [wcrsa_pkg::STATUS_W-1:0] status;
    logic [wcrsa_pkg::SLOT_W-1:0]   slot;
    logic [wcrsa_pkg::WORD_W-1:0]   base;
    logic [wcrsa_pkg::WORD_W-1:0]   mask;
    logic [wcrsa_pkg::SIZE_W-1:0]   region;
  } grant_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  // One line of the directed table: either a register write or a request.
  // Where typed is set, want holds the answer written out by hand.
  typedef struct {
    row_kind_t                        kind;
    logic [wcrsa_pkg::CFG_IDX_W-1:0]  idx;
    logic [wcrsa_pkg::CFG_DATA_W-1:0] data;
    logic [wcrsa_pkg::ADDR_W-1:0]     addr;
    logic [wcrsa_pkg::ADDR_W-1:0]     len;
    bit                               typed;
    grant_t                           want;
  } plan_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  logic [wcrsa_pkg::ADDR_W-1:0]     range_start_addr = '0;
  logic [wcrsa_pkg::ADDR_W-1:0]     range_length = '0;
  logic                             cfg_we = 1'b0;
  logic [wcrsa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wcrsa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                             done;
  logic [wcrsa_pkg::STATUS_W-1:0]   status;
  logic [wcrsa_pkg::SLOT_W-1:0]     slot_index;
  logic [wcrsa_pkg::WORD_W-1:0]     base_word;
  logic [wcrsa_pkg::WORD_W-1:0]     mask_word;
  logic [wcrsa_pkg::SIZE_W-1:0]     region_size;

  // Local copy of the register file and of the slots claimed so far. The
  // initial values are the reset defaults of the block.
  logic                             wc_on = 1'b1;
  logic [wcrsa_pkg::SLOT_CNT_W-1:0] slots_cfg = wcrsa_pkg::SLOT_COUNT_RESET;
  logic [wcrsa_pkg::PBITS_W-1:0]    pbits_cfg = wcrsa_pkg::PBITS_DEFAULT;
  logic [wcrsa_pkg::CFG_DATA_W-1:0] preowned_cfg = '0;
  logic [wcrsa_pkg::MAP_SLOTS-1:0]  claimed_map = '0;

  // Answers still owed by the block, oldest first.
  grant_t pending_grants[$];

  int mismatches    = 0;
  int words_sent    = 0;
  int regs_written  = 0;
  int grants_seen   = 0;
  int refusals_seen = 0;
  int cycle_count   = 0;

  wc_range_slot_allocator_unit dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .range_start_addr (range_start_addr),
    .range_length     (range_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .done             (done),
    .status           (status),
    .slot_index       (slot_index),
    .base_word        (base_word),
    .mask_word        (mask_word),
    .region_size      (region_size)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Works out the answer to one accepted request and claims the slot in the
  // local map, where the block claims it only when the grant is reported.
  function automatic grant_t encode_range(input logic [wcrsa_pkg::ADDR_W-1:0] a,
                                          input logic [wcrsa_pkg::ADDR_W-1:0] l);
    grant_t     g;
    logic [63:0] first_page;
    logic [63:0] end_page;
    logic [63:0] sz;
    logic [63:0] rbase;
    logic [63:0] wmask;
    logic [wcrsa_pkg::MAP_SLOTS-1:0] taken;
    int         lim;
    int         pb;
    int         pick;
    g = '0;
    if (l == '0) begin
      g.status = wcrsa_pkg::ST_ZERO_LEN;
    end else if (!wc_on) begin
      g.status = wcrsa_pkg::ST_NO_WC;
    end else if (slots_cfg == '0) begin
      g.status = wcrsa_pkg::ST_NO_SLOTS;
    end else begin
      // A slot count above what the map can hold is clipped.
      lim = slots_cfg;
      if (lim > wcrsa_pkg::MAX_SLOTS) lim = wcrsa_pkg::MAX_SLOTS;
      if (lim > wcrsa_pkg::MAP_SLOTS) lim = wcrsa_pkg::MAP_SLOTS;
      // An address width outside the legal window falls back to the default.
      pb = pbits_cfg;
      if (pb < int'(wcrsa_pkg::PBITS_MIN) || pb > int'(wcrsa_pkg::PBITS_MAX)) begin
        pb = int'(wcrsa_pkg::PBITS_DEFAULT);
      end
      first_page = {12'b0, a} & ~wcrsa_pkg::PAGE_LOW;
      end_page = ({12'b0, a} + {12'b0, l} + wcrsa_pkg::PAGE_LOW) & ~wcrsa_pkg::PAGE_LOW;
      sz = 64'd4096;
      while (sz < end_page - first_page) sz = sz << 1;
      rbase = first_page & ~(sz - 64'd1);
      while (rbase + sz < end_page) begin
        sz = sz << 1;
        rbase = first_page & ~(sz - 64'd1);
      end
      // Firmware-owned slots count as taken without ever entering the map.
      taken = claimed_map | preowned_cfg;
      pick = -1;
      for (int i = 0; i < lim; i++) begin
        if (pick < 0 && !taken[i]) pick = i;
      end
      if (pick < 0) begin
        g.status = wcrsa_pkg::ST_NO_FREE;
      end else begin
        claimed_map[pick] = 1'b1;
        wmask = (64'd1 << pb) - 64'd1;
        g.status = wcrsa_pkg::ST_OK;
        g.slot   = pick[wcrsa_pkg::SLOT_W-1:0];
        g.base   = (rbase & ~wcrsa_pkg::PAGE_LOW) | wcrsa_pkg::TYPE_WC;
        g.mask   = (wmask & ~(sz - 64'd1) & ~wcrsa_pkg::PAGE_LOW) | wcrsa_pkg::VALID_BIT;
        g.region = sz[wcrsa_pkg::SIZE_W-1:0];
      end
    end
    return g;
  endfunction

  function automatic grant_t answer(input logic [wcrsa_pkg::STATUS_W-1:0] st,
                                    input logic [wcrsa_pkg::SLOT_W-1:0] sl,
                                    input logic [wcrsa_pkg::WORD_W-1:0] b,
                                    input logic [wcrsa_pkg::WORD_W-1:0] m,
                                    input logic [wcrsa_pkg::SIZE_W-1:0] sz);
    grant_t g;
    g.status = st;
    g.slot   = sl;
    g.base   = b;
    g.mask   = m;
    g.region = sz;
    return g;
  endfunction

  function automatic plan_row_t cfg_row(input logic [wcrsa_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [wcrsa_pkg::CFG_DATA_W-1:0] d);
    plan_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.data  = d;
    r.addr  = '0;
    r.len   = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic plan_row_t req_row(input logic [wcrsa_pkg::ADDR_W-1:0] a,
                                        input logic [wcrsa_pkg::ADDR_W-1:0] l,
                                        input bit typed,
                                        input grant_t want);
    plan_row_t r;
    r.kind  = ROW_REQ;
    r.idx   = '0;
    r.data  = '0;
    r.addr  = a;
    r.len   = l;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Writes one register and mirrors it with the same field masking as the
  // block. The write enable is lowered again before the task returns.
  task automatic write_reg(input logic [wcrsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wcrsa_pkg::CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      wcrsa_pkg::CFG_WC_AVAILABLE:   wc_on = d[0];
      wcrsa_pkg::CFG_SLOT_COUNT:     slots_cfg = d[wcrsa_pkg::SLOT_CNT_W-1:0];
      wcrsa_pkg::CFG_PHYS_ADDR_BITS: pbits_cfg = d[wcrsa_pkg::PBITS_W-1:0];
      wcrsa_pkg::CFG_PREOWNED_SLOTS: preowned_cfg = d;
      default: ;
    endcase
    regs_written++;
    @(posedge clk);
  endtask

  // Presents one request word and returns at the edge that accepts it, with
  // start still high so that a following word can go out back to back.
  task automatic send_word(input logic [wcrsa_pkg::ADDR_W-1:0] a,
                           input logic [wcrsa_pkg::ADDR_W-1:0] l,
                           input bit typed, input grant_t want);
    grant_t predicted;
    start            <= 1'b1;
    range_start_addr <= a;
    range_length     <= l;
    do @(posedge clk); while (busy);
    predicted = encode_range(a, l);
    pending_grants.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  task automatic wait_idle();
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_field(input string field, input logic [63:0] want_v,
                              input logic [63:0] got_v);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
    mismatches++;
  endtask

  // Answer checker. The block cannot be stalled, so every cycle with done
  // high carries one answer word that must match the oldest expectation.
  always @(posedge clk) begin : answer_check
    grant_t want;
    if (!rst && done === 1'b1) begin
      if (status == wcrsa_pkg::ST_OK) grants_seen++;
      else refusals_seen++;
      if (pending_grants.size() == 0) begin
        $display("%0t: answer with nothing expected, got status %0d slot %0d",
                 $time, status, slot_index);
        $display("%0t:   base %h mask %h size %h",
                 $time, base_word, mask_word, region_size);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        if (status !== want.status) report_field("status", want.status, status);
        if (slot_index !== want.slot) report_field("slot_index", want.slot, slot_index);
        if (base_word !== want.base) report_field("base_word", want.base, base_word);
        if (mask_word !== want.mask) report_field("mask_word", want.mask, mask_word);
        if (region_size !== want.region) begin
          report_field("region_size", want.region, region_size);
        end
      end
    end
  end

  // Watchdog: a missing answer or a stuck busy ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    plan_row_t                        plan[$];
    logic [63:0]                      r;
    logic [wcrsa_pkg::ADDR_W-1:0]     a;
    logic [wcrsa_pkg::ADDR_W-1:0]     l;
    logic [wcrsa_pkg::CFG_DATA_W-1:0] d;
    int                               n;
    int                               k;
    int                               gap;
    int                               burst_left;
    int                               directed_words;
    bit                               hold;

    // Directed table. Answers are typed in where they follow at a glance;
    // the rest come from the local model.
    plan.push_back(req_row('0, '0, 1'b1,
                           answer(wcrsa_pkg::ST_ZERO_LEN, '0, '0, '0, '0)));
    plan.push_back(req_row(ADDR_MAX, '0, 1'b1,
                           answer(wcrsa_pkg::ST_ZERO_LEN, '0, '0, '0, '0)));
    // One byte at zero with the default 36-bit width: the smallest region.
    plan.push_back(req_row('0, 52'd1, 1'b1,
                           answer(wcrsa_pkg::ST_OK, 4'd0, 64'h1,
                                  64'h0000_000F_FFFF_F800, 54'd4096)));
    // Largest address and length: the region grows to 2^53 and the mask
    // keeps only the valid bit.
    plan.push_back(req_row(ADDR_MAX, ADDR_MAX, 1'b1,
                           answer(wcrsa_pkg::ST_OK, 4'd1, 64'h1,
                                  wcrsa_pkg::VALID_BIT, (54'd1 << 53))));
    // Two bytes across a page boundary force the alignment doubling.
    plan.push_back(req_row(52'h1fff, 52'd2, 1'b0, '0));
    plan.push_back(cfg_row(wcrsa_pkg::CFG_PHYS_ADDR_BITS, 16'd32));
    plan.push_back(req_row(52'h1234_5678, 52'h1_0000, 1'b0, '0));
    plan.push_back(cfg_row(wcrsa_pkg::CFG_PHYS_ADDR_BITS, 16'd52));
    plan.push_back(req_row(52'hF_FFFF_FFFF_F000, 52'h1000, 1'b0, '0));
    // Widths below and above the legal window both fall back to 36 bits.
    plan.push_back(cfg_row(wcrsa_pkg::CFG_PHYS_ADDR_BITS, 16'd0));
    plan.push_back(req_row(52'h8_0000_0123, 52'h7_FFFF, 1'b0, '0));
    plan.push_back(cfg_row(wcrsa_pkg::CFG_PHYS_ADDR_BITS, 16'hFFFF));
    plan.push_back(req_row(52'hABC_DEF0_1234, 52'h3_0000_0000, 1'b0, '0));
    // Every slot owned by firmware: nothing is free.
    plan.push_back(cfg_row(wcrsa_pkg::CFG_PREOWNED_SLOTS, 16'hFFFF));
    plan.push_back(req_row(52'h1000, 52'h1000, 1'b1,
                           answer(wcrsa_pkg::ST_NO_FREE, '0, '0, '0, '0)));
    // No slots at all; zero length still wins over that.
    plan.push_back(cfg_row(wcrsa_pkg::CFG_SLOT_COUNT, 16'd0));
    plan.push_back(req_row(52'h1000, '0, 1'b1,
                           answer(wcrsa_pkg::ST_ZERO_LEN, '0, '0, '0, '0)));
    plan.push_back(req_row(52'h1000, 52'd5, 1'b1,
                           answer(wcrsa_pkg::ST_NO_SLOTS, '0, '0, '0, '0)));
    // No write-combining support ranks above the missing slots.
    plan.push_back(cfg_row(wcrsa_pkg::CFG_WC_AVAILABLE, 16'd0));
    plan.push_back(req_row(52'h1000, 52'd5, 1'b1,
                           answer(wcrsa_pkg::ST_NO_WC, '0, '0, '0, '0)));
    // A slot count of 31 is clipped to 16; the low eight slots are preowned
    // and the map already holds slots zero to six, so slot eight is claimed.
    plan.push_back(cfg_row(wcrsa_pkg::CFG_WC_AVAILABLE, 16'd1));
    plan.push_back(cfg_row(wcrsa_pkg::CFG_SLOT_COUNT, 16'd31));
    plan.push_back(cfg_row(wcrsa_pkg::CFG_PREOWNED_SLOTS, 16'h00FF));
    plan.push_back(req_row(52'h3_0000_0800, 52'hF_F800, 1'b0, '0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register writes wait for the block to drain; requests get a short gap.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].addr, plan[i].len, plan[i].typed, plan[i].want);
        start <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
    directed_words = words_sent;

    // Random phases. Each phase drains the block, writes all four registers
    // (with junk in the unused data bits) and then sends bursts of words.
    // The slot count climbs phase by phase so that slot claims are spread
    // over the run rather than used up at once.
    burst_left = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      d = wcrsa_pkg::CFG_DATA_W'($urandom);
      d[0] = ($urandom_range(0, 5) != 0);
      write_reg(wcrsa_pkg::CFG_WC_AVAILABLE, d);
      d = wcrsa_pkg::CFG_DATA_W'($urandom);
      if (ph % 4 == 3) n = $urandom_range(0, 31);
      else n = (8 + ph > 16) ? 16 : 8 + ph;
      d[wcrsa_pkg::SLOT_CNT_W-1:0] = n[wcrsa_pkg::SLOT_CNT_W-1:0];
      write_reg(wcrsa_pkg::CFG_SLOT_COUNT, d);
      d = wcrsa_pkg::CFG_DATA_W'($urandom);
      if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 63);
      else n = $urandom_range(32, 52);
      d[wcrsa_pkg::PBITS_W-1:0] = n[wcrsa_pkg::PBITS_W-1:0];
      write_reg(wcrsa_pkg::CFG_PHYS_ADDR_BITS, d);
      d = ($urandom_range(0, 2) == 0) ? wcrsa_pkg::CFG_DATA_W'($urandom) : '0;
      write_reg(wcrsa_pkg::CFG_PREOWNED_SLOTS, d);

      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        r = {$urandom, $urandom};
        a = ($urandom_range(0, 2) == 0) ? {20'b0, r[31:0]} : r[wcrsa_pkg::ADDR_W-1:0];
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          0: l = '0;
          1, 2, 3, 4, 5: l = wcrsa_pkg::ADDR_W'($urandom_range(1, 65536));
          6, 7: begin
            // A length of k random bits, so region sizes spread over the range.
            k = $urandom_range(1, wcrsa_pkg::ADDR_W - 1);
            l = r[wcrsa_pkg::ADDR_W-1:0] >> (wcrsa_pkg::ADDR_W - k);
            if (l == '0) l = wcrsa_pkg::ADDR_W'(1);
          end
          8: l = r[wcrsa_pkg::ADDR_W-1:0];
          default: begin
            a = $urandom_range(0, 1) ? ADDR_MAX : wcrsa_pkg::ADDR_W'(0);
            l = $urandom_range(0, 1) ? ADDR_MAX : wcrsa_pkg::ADDR_W'(1);
          end
        endcase
        send_word(a, l, 1'b0, '0);

        if (burst_left > 0) begin
          burst_left--;
          gap = 0;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap = $urandom_range(1, 12);
        end
        // Now and then the sender holds off until every answer is in.
        hold = ($urandom_range(0, 59) == 0) || (ph == 0 && n == WORDS_PER_PHASE / 2);
        if (gap > 0 || hold || n == WORDS_PER_PHASE - 1) begin
          start <= 1'b0;
          repeat ((gap > 0) ? gap : 1) @(posedge clk);
          if (hold) begin
            while (pending_grants.size() != 0) @(posedge clk);
          end
        end
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d request words (%0d from the directed table) and %0d register writes.",
             words_sent, directed_words, regs_written);
    $display("Checked %0d slot grants and %0d refused requests.", grants_seen, refusals_seen);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/wcrsa_pkg.sv
sv/wcrsa_size_unit.sv
sv/wcrsa_slot_scan.sv
sv/wc_range_slot_allocator_unit.sv
bench/tb_top.sv
